>>> rtl/dwm_pkg.sv
package dwm_pkg;

  // drive modes
  localparam logic [1:0] MODE_ARCADE2 = 2'd0;
  localparam logic [1:0] MODE_ARCADE4 = 2'd1;
  localparam logic [1:0] MODE_MECANUM = 2'd2;
  localparam logic [1:0] MODE_FIELD   = 2'd3;

  localparam int CMD_W       = 8;
  localparam int LANE_W      = 11;
  localparam int DRIVE_LIMIT = 127;
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  // one mixed item waiting for normalization
  typedef struct packed {
    logic                   rear_used;
    logic [3:0][LANE_W-1:0] lanes;
  } mix_item_t;

  // quarter-wave sine, one entry per degree, unsigned Q1.15
  localparam logic [15:0] SINE_Q15 [0:90] = '{
    16'd0,     16'd572,   16'd1144,  16'd1715,  16'd2286,  16'd2856,  16'd3425,
    16'd3993,  16'd4560,  16'd5126,  16'd5690,  16'd6252,  16'd6813,  16'd7371,
    16'd7927,  16'd8481,  16'd9032,  16'd9580,  16'd10126, 16'd10668, 16'd11207,
    16'd11743, 16'd12275, 16'd12803, 16'd13328, 16'd13848, 16'd14365, 16'd14876,
    16'd15384, 16'd15886, 16'd16384, 16'd16877, 16'd17364, 16'd17847, 16'd18324,
    16'd18795, 16'd19261, 16'd19720, 16'd20174, 16'd20622, 16'd21063, 16'd21498,
    16'd21926, 16'd22348, 16'd22763, 16'd23170, 16'd23571, 16'd23965, 16'd24351,
    16'd24730, 16'd25102, 16'd25466, 16'd25822, 16'd26170, 16'd26510, 16'd26842,
    16'd27166, 16'd27482, 16'd27789, 16'd28088, 16'd28378, 16'd28660, 16'd28932,
    16'd29197, 16'd29452, 16'd29698, 16'd29935, 16'd30163, 16'd30382, 16'd30592,
    16'd30792, 16'd30983, 16'd31164, 16'd31336, 16'd31499, 16'd31651, 16'd31795,
    16'd31928, 16'd32052, 16'd32166, 16'd32270, 16'd32365, 16'd32449, 16'd32524,
    16'd32588, 16'd32643, 16'd32688, 16'd32723, 16'd32748, 16'd32763, 16'd32768
  };

  // table entry rescaled to fb fraction bits
  function automatic logic [16:0] sine_entry(input logic [6:0] idx, input int fb);
    logic [16:0] t;
    t = 17'(SINE_Q15[idx]);
    if (fb < 15) begin
      t = (t + (17'd1 << (14 - fb))) >> (15 - fb);
    end else if (fb > 15) begin
      t = t << (fb - 15);
    end
    return t;
  endfunction

endpackage

>>> rtl/dwm_if.sv
interface dwm_in_if;
  logic              valid;
  logic              ready;
  logic signed [7:0] forward_cmd;
  logic signed [7:0] turn_cmd;
  logic signed [7:0] strafe_cmd;
  logic        [8:0] heading_deg;

  modport source (output valid, forward_cmd, turn_cmd, strafe_cmd, heading_deg,
                  input ready);
  modport sink (input valid, forward_cmd, turn_cmd, strafe_cmd, heading_deg,
                output ready);
endinterface

interface dwm_out_if;
  logic              valid;
  logic              ready;
  logic signed [7:0] left_front_drive;
  logic signed [7:0] left_rear_drive;
  logic signed [7:0] right_front_drive;
  logic signed [7:0] right_rear_drive;
  logic              rear_used;

  modport source (output valid, left_front_drive, left_rear_drive, right_front_drive,
                  right_rear_drive, rear_used, input ready);
  modport sink (input valid, left_front_drive, left_rear_drive, right_front_drive,
                right_rear_drive, rear_used, output ready);
endinterface

>>> rtl/drive_wheel_mixer_top.sv
// four-wheel drive mixer with normalization
// in_ch carries forward, turn and strafe commands and a heading; out_ch carries
// the four wheel drives and rear_used. both use a valid/ready handshake.
// cfg_we/cfg_wdata write the 2-bit drive mode; write it only while no item
// is in flight.
// pipeline: an accepted item passes 4 front stages (trig lookup, products,
// rotated sums, mixing), one queue slot, then 10 back stages (max, dividend,
// 7 bit-steps of the normalizing divider, output register).
// throughput: one item per cycle while out_ch is not stalled, set by the
// pipelined divider which retires one quotient bit per stage for all four wheels.
// a stalled receiver holds the output register; the back stages freeze, the
// 4-entry queue fills and then the front stops taking items.
// reset clears all valid bits, empties the queue and sets the mode to
// arcade two motor.
module drive_wheel_mixer_top #(
  parameter int TRIG_FRACTION_BITS = 15
) (
  input  logic       clk,
  input  logic       rst_n,
  dwm_in_if.sink     in_ch,
  dwm_out_if.source  out_ch,
  input  logic       cfg_we,
  input  logic [1:0] cfg_wdata
);
  import dwm_pkg::*;

  logic      push_valid, push_ready;
  mix_item_t push_item;
  logic      pop_valid, pop_ready;
  mix_item_t pop_item;

  dwm_front #(
    .TRIG_FRACTION_BITS(TRIG_FRACTION_BITS)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .in_ch      (in_ch),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_item  (push_item)
  );

  dwm_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_item  (push_item),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_item   (pop_item)
  );

  dwm_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_item  (pop_item),
    .out_ch    (out_ch)
  );

endmodule

>>> rtl/dwm_front.sv
module dwm_front #(
  parameter int TRIG_FRACTION_BITS = 15
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic [1:0]        cfg_wdata,
  dwm_in_if.sink            in_ch,
  output logic              push_valid,
  input  logic              push_ready,
  output dwm_pkg::mix_item_t push_item
);
  import dwm_pkg::*;

  localparam int TW = TRIG_FRACTION_BITS + 2;
  localparam int PW = TW + CMD_W;
  localparam int SW = PW + 1;

  logic [1:0] mode_r;

  logic en;

  // stage 0: captured commands and trig values
  logic                 v0_r;
  logic signed [7:0]    f0_r, t0_r, s0_r;
  logic [1:0]           m0_r;
  logic signed [TW-1:0] sn0_r, cs0_r;
  // stage 1: products
  logic                 v1_r;
  logic signed [7:0]    f1_r, t1_r, s1_r;
  logic [1:0]           m1_r;
  logic signed [PW-1:0] p_fc_r, p_ss_r, p_fs_r, p_sc_r;
  // stage 2: rotated sums
  logic                 v2_r;
  logic signed [7:0]    f2_r, t2_r, s2_r;
  logic [1:0]           m2_r;
  logic signed [SW-1:0] rf_r, rs_r;
  // stage 3: mixed lanes
  logic                 v3_r;
  mix_item_t            item3_r;

  logic [8:0]           head_a, head_c, head_c_raw;
  logic [7:0]           fold_s, fold_c;
  logic [TW-1:0]        mag_s, mag_c;
  logic signed [TW-1:0] sn_nxt, cs_nxt;

  logic signed [SW-1:0]     rf_adj, rs_adj;
  logic signed [LANE_W-1:0] rot_f, rot_s, fe, te, se;
  mix_item_t                item3_nxt;

  // returns {negative, quarter-wave index}
  function automatic logic [7:0] fold_deg(input logic [8:0] a);
    logic [8:0] d;
    logic       neg;
    neg = 1'b0;
    if (a <= 9'd90) begin
      d = a;
    end else if (a <= 9'd180) begin
      d = 9'd180 - a;
    end else if (a <= 9'd270) begin
      d = a - 9'd180;
      neg = 1'b1;
    end else begin
      d = 9'd360 - a;
      neg = 1'b1;
    end
    return {neg, d[6:0]};
  endfunction

  assign en          = !v3_r || push_ready;
  assign in_ch.ready = en;
  assign push_valid  = v3_r;
  assign push_item   = item3_r;

  // heading reduction and sine/cosine lookup
  always_comb begin
    head_a     = (in_ch.heading_deg >= 9'd360) ? in_ch.heading_deg - 9'd360
                                               : in_ch.heading_deg;
    head_c_raw = head_a + 9'd90;
    head_c     = (head_c_raw >= 9'd360) ? head_c_raw - 9'd360 : head_c_raw;
    fold_s     = fold_deg(head_a);
    fold_c     = fold_deg(head_c);
    mag_s      = TW'(sine_entry(fold_s[6:0], TRIG_FRACTION_BITS));
    mag_c      = TW'(sine_entry(fold_c[6:0], TRIG_FRACTION_BITS));
    sn_nxt     = fold_s[7] ? -$signed(mag_s) : $signed(mag_s);
    cs_nxt     = fold_c[7] ? -$signed(mag_c) : $signed(mag_c);
  end

  // truncate rotated sums toward zero, then mix
  always_comb begin
    rf_adj = rf_r + ((rf_r < 0) ? SW'((1 << TRIG_FRACTION_BITS) - 1) : SW'(0));
    rs_adj = rs_r + ((rs_r < 0) ? SW'((1 << TRIG_FRACTION_BITS) - 1) : SW'(0));
    rot_f  = rf_adj[SW-1:TRIG_FRACTION_BITS];
    rot_s  = rs_adj[SW-1:TRIG_FRACTION_BITS];
    te     = LANE_W'(t2_r);
    fe     = (m2_r == MODE_FIELD) ? rot_f : LANE_W'(f2_r);
    se     = (m2_r == MODE_FIELD) ? rot_s : LANE_W'(s2_r);
    item3_nxt.rear_used = (m2_r != MODE_ARCADE2);
    if (m2_r == MODE_ARCADE2 || m2_r == MODE_ARCADE4) begin
      // rear lanes mirror the fronts so the shared max stays the same
      item3_nxt.lanes[0] = fe + te;
      item3_nxt.lanes[1] = fe + te;
      item3_nxt.lanes[2] = fe - te;
      item3_nxt.lanes[3] = fe - te;
    end else begin
      item3_nxt.lanes[0] = fe + te + se;
      item3_nxt.lanes[1] = fe + te - se;
      item3_nxt.lanes[2] = fe - te - se;
      item3_nxt.lanes[3] = fe - te + se;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_ARCADE2;
      v0_r   <= 1'b0;
      v1_r   <= 1'b0;
      v2_r   <= 1'b0;
      v3_r   <= 1'b0;
    end else begin
      if (cfg_we) begin
        mode_r <= cfg_wdata;
      end
      if (en) begin
        v0_r <= in_ch.valid;
        v1_r <= v0_r;
        v2_r <= v1_r;
        v3_r <= v2_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      f0_r   <= in_ch.forward_cmd;
      t0_r   <= in_ch.turn_cmd;
      s0_r   <= in_ch.strafe_cmd;
      m0_r   <= mode_r;
      sn0_r  <= sn_nxt;
      cs0_r  <= cs_nxt;

      f1_r   <= f0_r;
      t1_r   <= t0_r;
      s1_r   <= s0_r;
      m1_r   <= m0_r;
      p_fc_r <= PW'(f0_r) * PW'(cs0_r);
      p_ss_r <= PW'(s0_r) * PW'(sn0_r);
      p_fs_r <= PW'(f0_r) * PW'(sn0_r);
      p_sc_r <= PW'(s0_r) * PW'(cs0_r);

      f2_r   <= f1_r;
      t2_r   <= t1_r;
      s2_r   <= s1_r;
      m2_r   <= m1_r;
      rf_r   <= SW'(p_fc_r) - SW'(p_ss_r);
      rs_r   <= SW'(p_fs_r) + SW'(p_sc_r);

      item3_r <= item3_nxt;
    end
  end

endmodule

>>> rtl/dwm_queue.sv
module dwm_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push_valid,
  output logic               push_ready,
  input  dwm_pkg::mix_item_t push_item,
  output logic               pop_valid,
  input  logic               pop_ready,
  output dwm_pkg::mix_item_t pop_item
);
  import dwm_pkg::*;

  mix_item_t         mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [QPTR_W:0]   count_r;
  logic              do_push, do_pop;

  assign push_ready = (count_r != (QPTR_W+1)'(QUEUE_DEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_item   = mem_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + 1'b1;
      end else if (do_pop && !do_push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

>>> rtl/dwm_back.sv
module dwm_back (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               pop_valid,
  output logic               pop_ready,
  input  dwm_pkg::mix_item_t pop_item,
  dwm_out_if.source          out_ch
);
  import dwm_pkg::*;

  // stage 0 max, stage 1 dividend, stages 2..8 one quotient bit each
  localparam int LAST = 8;
  localparam int RW   = LANE_W + 7;

  logic en;

  logic              vld_r  [0:LAST];
  logic [LANE_W-1:0] mx_r   [0:LAST];
  logic              big_r  [0:LAST];
  logic              rear_r [0:LAST];
  logic [3:0]        neg_r  [0:LAST];
  logic [3:0][7:0]   orig_r [0:LAST];
  logic [LANE_W-1:0] abs0_r [4];
  logic [RW-1:0]     rem_r  [1:LAST][4];
  logic [6:0]        q_r    [1:LAST][4];

  logic [LANE_W-1:0] abs_nxt [4];
  logic [3:0]        neg_nxt;
  logic [LANE_W-1:0] m01, m23, mx_nxt;
  logic [RW-1:0]     rem_nxt [2:LAST][4];
  logic [6:0]        q_nxt   [2:LAST][4];
  logic [7:0]        drv_nxt [4];

  logic              out_valid_r;
  logic [7:0]        drv_r [4];
  logic              out_rear_r;

  assign en        = !out_valid_r || out_ch.ready;
  assign pop_ready = en;

  // magnitudes and their max
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      neg_nxt[i] = pop_item.lanes[i][LANE_W-1];
      abs_nxt[i] = neg_nxt[i] ? -pop_item.lanes[i] : pop_item.lanes[i];
    end
    m01    = (abs_nxt[0] > abs_nxt[1]) ? abs_nxt[0] : abs_nxt[1];
    m23    = (abs_nxt[2] > abs_nxt[3]) ? abs_nxt[2] : abs_nxt[3];
    mx_nxt = (m01 > m23) ? m01 : m23;
  end

  // restoring division steps
  always_comb begin
    logic [RW-1:0] dsh;
    logic          ge;
    for (int s = 2; s <= LAST; s++) begin
      dsh = RW'(mx_r[s-1]) << (LAST - s);
      for (int i = 0; i < 4; i++) begin
        ge            = (rem_r[s-1][i] >= dsh);
        rem_nxt[s][i] = ge ? rem_r[s-1][i] - dsh : rem_r[s-1][i];
        q_nxt[s][i]   = {q_r[s-1][i][5:0], ge};
      end
    end
  end

  // sign, pass-through and rear blanking
  always_comb begin
    logic [7:0] qs;
    for (int i = 0; i < 4; i++) begin
      qs = {1'b0, q_r[LAST][i]};
      if (!big_r[LAST]) begin
        drv_nxt[i] = orig_r[LAST][i];
      end else begin
        drv_nxt[i] = neg_r[LAST][i] ? -qs : qs;
      end
      if (!rear_r[LAST] && (i == 1 || i == 3)) begin
        drv_nxt[i] = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int s = 0; s <= LAST; s++) begin
        vld_r[s] <= 1'b0;
      end
      out_valid_r <= 1'b0;
    end else if (en) begin
      vld_r[0] <= pop_valid;
      for (int s = 1; s <= LAST; s++) begin
        vld_r[s] <= vld_r[s-1];
      end
      out_valid_r <= vld_r[LAST];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mx_r[0]   <= mx_nxt;
      big_r[0]  <= (mx_nxt > LANE_W'(DRIVE_LIMIT));
      rear_r[0] <= pop_item.rear_used;
      neg_r[0]  <= neg_nxt;
      for (int i = 0; i < 4; i++) begin
        orig_r[0][i] <= pop_item.lanes[i][7:0];
        abs0_r[i]    <= abs_nxt[i];
        rem_r[1][i]  <= (RW'(abs0_r[i]) << 7) - RW'(abs0_r[i]);
        q_r[1][i]    <= '0;
      end
      for (int s = 1; s <= LAST; s++) begin
        mx_r[s]   <= mx_r[s-1];
        big_r[s]  <= big_r[s-1];
        rear_r[s] <= rear_r[s-1];
        neg_r[s]  <= neg_r[s-1];
        orig_r[s] <= orig_r[s-1];
      end
      for (int s = 2; s <= LAST; s++) begin
        for (int i = 0; i < 4; i++) begin
          rem_r[s][i] <= rem_nxt[s][i];
          q_r[s][i]   <= q_nxt[s][i];
        end
      end
      for (int i = 0; i < 4; i++) begin
        drv_r[i] <= drv_nxt[i];
      end
      out_rear_r <= rear_r[LAST];
    end
  end

  assign out_ch.valid             = out_valid_r;
  assign out_ch.left_front_drive  = drv_r[0];
  assign out_ch.left_rear_drive   = drv_r[1];
  assign out_ch.right_front_drive = drv_r[2];
  assign out_ch.right_rear_drive  = drv_r[3];
  assign out_ch.rear_used         = out_rear_r;

endmodule

>>> tb/sv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import dwm_pkg::*;

  localparam int TRIG_FB = 15;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_PAD = 30;
  localparam int PHASE_ITEMS = 244;

  // quarter-wave sine, round(sin * 32768), one entry per degree
  localparam int SINE_TABLE [0:90] = '{
    0, 572, 1144, 1715, 2286, 2856, 3425, 3993, 4560, 5126,
    5690, 6252, 6813, 7371, 7927, 8481, 9032, 9580, 10126, 10668,
    11207, 11743, 12275, 12803, 13328, 13848, 14365, 14876, 15384, 15886,
    16384, 16877, 17364, 17847, 18324, 18795, 19261, 19720, 20174, 20622,
    21063, 21498, 21926, 22348, 22763, 23170, 23571, 23965, 24351, 24730,
    25102, 25466, 25822, 26170, 26510, 26842, 27166, 27482, 27789, 28088,
    28378, 28660, 28932, 29197, 29452, 29698, 29935, 30163, 30382, 30592,
    30792, 30983, 31164, 31336, 31499, 31651, 31795, 31928, 32052, 32166,
    32270, 32365, 32449, 32524, 32588, 32643, 32688, 32723, 32748, 32763,
    32768
  };

  typedef struct {
    logic signed [7:0] fwd;
    logic signed [7:0] turn;
    logic signed [7:0] strafe;
    logic        [8:0] heading;
  } wheel_cmd_t;

  typedef struct {
    logic signed [7:0] lf;
    logic signed [7:0] lr;
    logic signed [7:0] rf;
    logic signed [7:0] rr;
    logic              rear;
  } drive_set_t;

  logic       clk;
  logic       rst_n;
  logic       cfg_we;
  logic [1:0] cfg_wdata;

  dwm_in_if  in_if();
  dwm_out_if out_if();

  drive_wheel_mixer_top #(
    .TRIG_FRACTION_BITS(TRIG_FB)
  ) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_if),
    .out_ch   (out_if),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  wheel_cmd_t cmds_to_send [$];
  drive_set_t drive_sets_due [$];
  logic [1:0] mode_now = MODE_ARCADE2;
  int         send_idle_pct = 0;
  int         recv_stall_pct = 0;
  int         fail_count = 0;
  int         quiet_cycles = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int quarter_sine(int deg);
    int down;
    int up;
    int v;
    down = (TRIG_FB < 15) ? 15 - TRIG_FB : 0;
    up = (TRIG_FB > 15) ? TRIG_FB - 15 : 0;
    v = SINE_TABLE[deg];
    v = ((v + ((1 << down) >> 1)) >> down) << up;
    return v;
  endfunction

  function automatic int sine_deg(int deg);
    if (deg <= 90) begin
      return quarter_sine(deg);
    end else if (deg <= 180) begin
      return quarter_sine(180 - deg);
    end else if (deg <= 270) begin
      return -quarter_sine(deg - 180);
    end
    return -quarter_sine(360 - deg);
  endfunction

  function automatic drive_set_t mix_wheels(wheel_cmd_t c, logic [1:0] mode);
    int f;
    int t;
    int s;
    int a;
    int sn;
    int cs;
    int nf;
    int ns;
    int mx;
    int n;
    int i;
    int w [4];
    drive_set_t r;
    f = c.fwd;
    t = c.turn;
    s = c.strafe;
    if (mode == MODE_ARCADE2 || mode == MODE_ARCADE4) begin
      w[0] = f + t;
      w[1] = f - t;
      w[2] = 0;
      w[3] = 0;
      n = 2;
    end else begin
      if (mode == MODE_FIELD) begin
        // headings past a full turn wrap once
        a = int'(c.heading);
        if (a >= 360) a = a - 360;
        sn = sine_deg(a);
        cs = sine_deg((a + 90) % 360);
        nf = (f * cs - s * sn) / (1 << TRIG_FB);
        ns = (f * sn + s * cs) / (1 << TRIG_FB);
        f = nf;
        s = ns;
      end
      w[0] = f + t + s;
      w[1] = f + t - s;
      w[2] = f - t - s;
      w[3] = f - t + s;
      n = 4;
    end
    mx = 0;
    for (i = 0; i < n; i++) begin
      if ((w[i] < 0 ? -w[i] : w[i]) > mx) mx = (w[i] < 0 ? -w[i] : w[i]);
    end
    if (mx > DRIVE_LIMIT) begin
      for (i = 0; i < n; i++) w[i] = (DRIVE_LIMIT * w[i]) / mx;
    end
    if (n == 2) begin
      r.lf = 8'(w[0]);
      r.rf = 8'(w[1]);
      r.lr = (mode == MODE_ARCADE4) ? 8'(w[0]) : 8'sd0;
      r.rr = (mode == MODE_ARCADE4) ? 8'(w[1]) : 8'sd0;
      r.rear = (mode == MODE_ARCADE4);
    end else begin
      r.lf = 8'(w[0]);
      r.lr = 8'(w[1]);
      r.rf = 8'(w[2]);
      r.rr = 8'(w[3]);
      r.rear = 1'b1;
    end
    return r;
  endfunction

  function automatic void queue_cmd(logic signed [7:0] f, logic signed [7:0] t,
                                    logic signed [7:0] s, logic [8:0] h);
    wheel_cmd_t c;
    c.fwd = f;
    c.turn = t;
    c.strafe = s;
    c.heading = h;
    cmds_to_send.push_back(c);
  endfunction

  function automatic logic signed [7:0] rand_power();
    logic signed [7:0] v;
    case ($urandom_range(3))
      0: v = 8'($urandom_range(20) - 10);
      1: begin
        case ($urandom_range(3))
          0: v = -8'sd128;
          1: v = -8'sd127;
          2: v = 8'sd127;
          default: v = 8'sd0;
        endcase
      end
      default: v = 8'($urandom_range(255));
    endcase
    return v;
  endfunction

  task automatic check_field(string name, int want, int got);
    if (want != got) begin
      $display("%0t: %s expected %0d got %0d", $time, name, want, got);
      fail_count++;
    end
  endtask

  // everything sent has come back and nothing is on the input bus
  task automatic wait_drained();
    @(negedge clk);
    while (cmds_to_send.size() != 0 || drive_sets_due.size() != 0 || in_if.valid)
      @(negedge clk);
  endtask

  task automatic write_mode(logic [1:0] m);
    wait_drained();
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= m;
    @(posedge clk);
    cfg_we <= 1'b0;
    mode_now = m;
  endtask

  // driver
  always @(posedge clk) begin : drive_cmds
    wheel_cmd_t nxt;
    if (!rst_n) begin
      in_if.valid <= 1'b0;
    end else begin
      if (in_if.valid && in_if.ready) begin
        nxt.fwd = in_if.forward_cmd;
        nxt.turn = in_if.turn_cmd;
        nxt.strafe = in_if.strafe_cmd;
        nxt.heading = in_if.heading_deg;
        drive_sets_due.push_back(mix_wheels(nxt, mode_now));
      end
      if (!in_if.valid || in_if.ready) begin
        if (cmds_to_send.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          nxt = cmds_to_send.pop_front();
          in_if.valid <= 1'b1;
          in_if.forward_cmd <= nxt.fwd;
          in_if.turn_cmd <= nxt.turn;
          in_if.strafe_cmd <= nxt.strafe;
          in_if.heading_deg <= nxt.heading;
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin : check_drives
    drive_set_t want;
    if (!rst_n) begin
      out_if.ready <= 1'b0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        if (drive_sets_due.size() == 0) begin
          $display("%0t: unexpected item, expected none got lf %0d lr %0d rf %0d rr %0d rear %0d",
                   $time, out_if.left_front_drive, out_if.left_rear_drive,
                   out_if.right_front_drive, out_if.right_rear_drive, out_if.rear_used);
          fail_count++;
        end else begin
          want = drive_sets_due.pop_front();
          check_field("left_front_drive", want.lf, out_if.left_front_drive);
          check_field("left_rear_drive", want.lr, out_if.left_rear_drive);
          check_field("right_front_drive", want.rf, out_if.right_front_drive);
          check_field("right_rear_drive", want.rr, out_if.right_rear_drive);
          check_field("rear_used", want.rear, out_if.rear_used);
        end
      end
      out_if.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("%0t: no item moved for %0d cycles", $time, WATCHDOG_LIMIT);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin : stim
    logic [1:0] plain_modes [3] = '{MODE_ARCADE2, MODE_ARCADE4, MODE_MECANUM};
    logic [1:0] phase_mode [8] = '{MODE_FIELD, MODE_MECANUM, MODE_ARCADE4, MODE_ARCADE2,
                                   MODE_MECANUM, MODE_FIELD, MODE_ARCADE2, MODE_ARCADE4};
    int send_plan [4] = '{0, 66, 0, 10};
    int recv_plan [4] = '{0, 0, 66, 10};
    int p;
    int k;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    in_if.valid = 1'b0;
    in_if.forward_cmd = '0;
    in_if.turn_cmd = '0;
    in_if.strafe_cmd = '0;
    in_if.heading_deg = '0;
    out_if.ready = 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // directed: command extremes in the plain modes
    for (p = 0; p < 3; p++) begin
      write_mode(plain_modes[p]);
      queue_cmd(8'sd127, 8'sd127, 8'sd127, 9'd0);
      queue_cmd(-8'sd128, -8'sd128, -8'sd128, 9'd511);
      queue_cmd(-8'sd127, 8'sd127, -8'sd127, 9'd0);
      queue_cmd(8'sd127, -8'sd128, 8'sd0, 9'd90);
      queue_cmd(8'sd0, 8'sd0, 8'sd0, 9'd0);
    end
    // directed: field centric across quadrants and past a full turn
    write_mode(MODE_FIELD);
    queue_cmd(8'sd127, 8'sd0, 8'sd0, 9'd0);
    queue_cmd(8'sd127, 8'sd0, -8'sd128, 9'd90);
    queue_cmd(-8'sd128, 8'sd10, 8'sd127, 9'd180);
    queue_cmd(8'sd100, -8'sd50, 8'sd60, 9'd270);
    queue_cmd(8'sd127, 8'sd127, 8'sd127, 9'd359);
    queue_cmd(-8'sd128, -8'sd128, -8'sd128, 9'd360);
    queue_cmd(8'sd50, 8'sd0, -8'sd50, 9'd450);
    queue_cmd(8'sd127, -8'sd1, 8'sd1, 9'd511);
    queue_cmd(-8'sd127, 8'sd0, 8'sd127, 9'd45);

    for (p = 0; p < 8; p++) begin
      write_mode(phase_mode[p]);
      send_idle_pct = send_plan[p % 4];
      recv_stall_pct = recv_plan[p % 4];
      for (k = 0; k < PHASE_ITEMS; k++) begin
        // sender holds off halfway until the pipe is empty
        if (k == PHASE_ITEMS / 2) wait_drained();
        queue_cmd(rand_power(), rand_power(), rand_power(),
                  ($urandom_range(4) == 0) ? 9'($urandom_range(511))
                                           : 9'($urandom_range(359)));
      end
    end

    wait_drained();
    repeat (DRAIN_PAD) @(posedge clk);
    if (fail_count == 0 && drive_sets_due.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
